FILE: src/mpc_pkg.sv
`timescale 1ns / 1ps
package mpc_pkg;

    localparam int MPC_TABLE_DEPTH = 16;
    localparam int ADDRESS_BITS    = 32;
    localparam int LEN_W           = 6;
    localparam int REMOVED_W       = 5;
    localparam int KIND_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 48;

    localparam logic [KIND_W-1:0] KIND_ADD_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DRAINED    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY      = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_STORED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_COVERED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] addr;
        logic [LEN_W-1:0]        len;
    } t_entry;

    typedef struct packed {
        logic old_covers_new;
        logic new_covers_old;
    } t_cover;

    // network mask for a length already limited to ADDRESS_BITS; zero length gives zero
    function automatic logic [ADDRESS_BITS-1:0] f_net_mask(input logic [LEN_W-1:0] len);
        f_net_mask = {ADDRESS_BITS{1'b1}} << (LEN_W'(ADDRESS_BITS) - len);
    endfunction

endpackage

FILE: src/mpc_table.sv
`timescale 1ns / 1ps
module mpc_table import mpc_pkg::*; #(
    parameter int TABLE_DEPTH = MPC_TABLE_DEPTH,
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/mpc_cover.sv
`timescale 1ns / 1ps
module mpc_cover import mpc_pkg::*; (
    input  t_entry i_new,
    input  t_entry i_stored,
    output t_cover o_cover
);

    logic [ADDRESS_BITS-1:0] w_mask_stored;
    logic [ADDRESS_BITS-1:0] w_mask_new;

    // both addresses are already masked to their own lengths
    assign w_mask_stored = f_net_mask(i_stored.len);
    assign w_mask_new    = f_net_mask(i_new.len);

    assign o_cover.old_covers_new = (i_stored.len <= i_new.len) &&
                                    ((i_new.addr & w_mask_stored) == i_stored.addr);
    assign o_cover.new_covers_old = (i_new.len <= i_stored.len) &&
                                    ((i_stored.addr & w_mask_new) == i_new.addr);

endmodule

FILE: src/modified_prefix_coalescer.sv
`timescale 1ns / 1ps
// Modified prefix coalescer.
// Input stream s_axis: tuser = mode (0 add, 1 drain); tdata = prefix address and length.
// Output stream m_axis: tuser = result kind; tdata = status, removed count, drained
// prefix; tlast marks the final result item of each input item.
// An add scans the table once through the shared cover unit, then compacts the
// survivors in a second pass over the table's one read port and appends; the result
// becomes valid in the same cycle that ready returns. A covered or dropped add skips
// the compaction pass. A drain reads each entry from the table and then loads it into
// the output register, reading the next entry only after that load.
// s_axis_tready is high only while the sequencer is idle; one item is processed at a
// time. Results sit in an output register, so the next input item is taken while
// the previous result still waits for m_axis_tready. When the receiver stalls, a
// drain pauses on the entry being output and resumes when the register empties.
// Reset (i_rst_n low, synchronous) empties the table and the output register; no
// clearing pass is needed since entries beyond the stored count are never read.
module modified_prefix_coalescer import mpc_pkg::*; #(
    parameter int TABLE_DEPTH = MPC_TABLE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] prefix_address, [37:32] prefix_length, [39:38] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] add_status, [6:2] removed_count, [38:7] out_address,
    // [44:39] out_length, [47:45] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] result_kind
    output logic [KIND_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SCAN      = 3'd1;
    localparam logic [2:0] ST_DECIDE    = 3'd2;
    localparam logic [2:0] ST_COMPACT   = 3'd3;
    localparam logic [2:0] ST_APPEND    = 3'd4;
    localparam logic [2:0] ST_RESULT    = 3'd5;
    localparam logic [2:0] ST_DRAIN_RD  = 3'd6;
    localparam logic [2:0] ST_DRAIN_OUT = 3'd7;

    logic [2:0]          r_state,      n_state;
    logic [CW-1:0]       r_rd_idx,     n_rd_idx;
    logic [CW-1:0]       r_wr_idx,     n_wr_idx;
    logic                r_pend,       n_pend;
    logic                r_covered,    n_covered;
    logic [CW-1:0]       r_removed,    n_removed;
    logic [CW-1:0]       r_count,      n_count;
    t_entry              r_new,        n_new;
    logic [KIND_W-1:0]   r_res_kind,   n_res_kind;
    logic [STATUS_W-1:0] r_res_status, n_res_status;

    logic                r_out_valid,   n_out_valid;
    logic [KIND_W-1:0]   r_out_kind,    n_out_kind;
    logic [STATUS_W-1:0] r_out_status,  n_out_status;
    logic [REMOVED_W-1:0] r_out_removed, n_out_removed;
    t_entry              r_out_entry,   n_out_entry;
    logic                r_out_last,    n_out_last;

    logic                    w_rd_en;
    logic [IW-1:0]           w_rd_addr;
    logic                    w_wr_en;
    logic [IW-1:0]           w_wr_addr;
    t_entry                  w_wr_data;
    t_entry                  w_rd_data;
    t_cover                  w_cover;
    logic                    w_slot_free;
    logic                    w_accept;
    logic [LEN_W-1:0]        w_in_len;
    logic [ADDRESS_BITS-1:0] w_in_addr;

    mpc_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_en  (w_rd_en),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    mpc_cover u_cover (
        .i_new   (r_new),
        .i_stored(w_rd_data),
        .o_cover (w_cover)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    assign w_in_len  = (s_axis_tdata[37:32] > LEN_W'(ADDRESS_BITS)) ?
                       LEN_W'(ADDRESS_BITS) : s_axis_tdata[37:32];
    assign w_in_addr = s_axis_tdata[31:0] & f_net_mask(w_in_len);

    always_comb begin
        n_state       = r_state;
        n_rd_idx      = r_rd_idx;
        n_wr_idx      = r_wr_idx;
        n_pend        = 1'b0;
        n_covered     = r_covered;
        n_removed     = r_removed;
        n_count       = r_count;
        n_new         = r_new;
        n_res_kind    = r_res_kind;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_kind    = r_out_kind;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        n_out_entry   = r_out_entry;
        n_out_last    = r_out_last;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_rd_idx[IW-1:0];
        w_wr_en       = 1'b0;
        w_wr_addr     = r_wr_idx[IW-1:0];
        w_wr_data     = w_rd_data;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_new.addr = w_in_addr;
                    n_new.len  = w_in_len;
                    n_rd_idx   = '0;
                    n_wr_idx   = '0;
                    n_covered  = 1'b0;
                    n_removed  = '0;
                    if (s_axis_tuser[0]) begin
                        if (r_count == '0) begin
                            n_res_kind   = KIND_EMPTY;
                            n_res_status = STATUS_STORED;
                            n_state      = ST_RESULT;
                        end else begin
                            n_state = ST_DRAIN_RD;
                        end
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // read entry i while judging entry i-1
                w_rd_en = (r_rd_idx < r_count);
                n_pend  = w_rd_en;
                if (w_rd_en) begin
                    n_rd_idx = CW'(r_rd_idx + 1'b1);
                end
                if (r_pend) begin
                    n_covered = r_covered || w_cover.old_covers_new;
                    if (w_cover.new_covers_old) begin
                        n_removed = CW'(r_removed + 1'b1);
                    end
                end
                if (!w_rd_en && !r_pend) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_res_kind = KIND_ADD_STATUS;
                n_rd_idx   = '0;
                n_wr_idx   = '0;
                if (r_covered) begin
                    n_res_status = STATUS_COVERED;
                    n_removed    = '0;
                    n_state      = ST_RESULT;
                end else if ((r_count - r_removed) >= CW'(TABLE_DEPTH)) begin
                    n_res_status = STATUS_FULL;
                    n_removed    = '0;
                    n_state      = ST_RESULT;
                end else begin
                    n_state = ST_COMPACT;
                end
            end
            ST_COMPACT: begin
                // write pointer trails the read pointer, so writes hit read slots
                w_rd_en = (r_rd_idx < r_count);
                n_pend  = w_rd_en;
                if (w_rd_en) begin
                    n_rd_idx = CW'(r_rd_idx + 1'b1);
                end
                if (r_pend && !w_cover.new_covers_old) begin
                    w_wr_en  = 1'b1;
                    n_wr_idx = CW'(r_wr_idx + 1'b1);
                end
                if (!w_rd_en && !r_pend) begin
                    n_state = ST_APPEND;
                end
            end
            ST_APPEND: begin
                w_wr_en      = 1'b1;
                w_wr_data    = r_new;
                n_count      = CW'(r_wr_idx + 1'b1);
                n_res_status = STATUS_STORED;
                n_state      = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = r_res_kind;
                    n_out_status  = r_res_status;
                    n_out_removed = REMOVED_W'(r_removed);
                    n_out_entry   = '0;
                    n_out_last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_DRAIN_RD: begin
                w_rd_en = 1'b1;
                n_state = ST_DRAIN_OUT;
            end
            ST_DRAIN_OUT: begin
                if (w_slot_free) begin
                    n_out_valid   = 1'b1;
                    n_out_kind    = KIND_DRAINED;
                    n_out_status  = STATUS_STORED;
                    n_out_removed = '0;
                    n_out_entry   = w_rd_data;
                    n_out_last    = (CW'(r_rd_idx + 1'b1) == r_count);
                    if (CW'(r_rd_idx + 1'b1) == r_count) begin
                        n_count = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = CW'(r_rd_idx + 1'b1);
                        n_state  = ST_DRAIN_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx      <= n_rd_idx;
        r_wr_idx      <= n_wr_idx;
        r_covered     <= n_covered;
        r_removed     <= n_removed;
        r_new         <= n_new;
        r_res_kind    <= n_res_kind;
        r_res_status  <= n_res_status;
        r_out_kind    <= n_out_kind;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
        r_out_entry   <= n_out_entry;
        r_out_last    <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {3'b000, r_out_entry.len, r_out_entry.addr,
                            r_out_removed, r_out_status};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("stored count beyond table depth");

    a_wr_trails_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMPACT) |-> (r_wr_idx <= r_rd_idx))
        else $error("compaction write pointer passed read pointer");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while still busy");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (($past(r_state) == ST_DRAIN_OUT) && (r_state == ST_IDLE)) |-> (r_count == '0))
        else $error("drain finished with entries left");

    a_add_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && w_slot_free) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("add or empty drain result not presented as last");
`endif

endmodule

FILE: tb/mpc_test_pkg.sv
`timescale 1ns / 1ps
package mpc_test_pkg;
    import mpc_pkg::*;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // one result item as seen on the master side, split into its fields
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [STATUS_W-1:0]     status;
        logic [REMOVED_W-1:0]    removed;
        logic [ADDRESS_BITS-1:0] addr;
        logic [LEN_W-1:0]        len;
        logic                    last;
    } t_result;

endpackage

FILE: tb/prefix_table_checker.sv
`timescale 1ns / 1ps
module prefix_table_checker import mpc_pkg::*; import mpc_test_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    // [31:0] prefix_address, [37:32] prefix_length, [39:38] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] mode
    input  logic [0:0]             i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    // [1:0] add_status, [6:2] removed_count, [38:7] out_address,
    // [44:39] out_length, [47:45] zero
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    // [1:0] result_kind
    input  logic [KIND_W-1:0]      i_m_tuser,
    input  logic                   i_m_tlast,
    output int                     o_error_count,
    output int                     o_pending_count,
    output int                     o_result_count
);

    t_entry  held [MPC_TABLE_DEPTH];
    int      held_count;
    t_result due_results [$];

    function automatic logic [ADDRESS_BITS-1:0] mask_of(input int len);
        if (len == 0)
            return '0;
        return {ADDRESS_BITS{1'b1}} << (ADDRESS_BITS - len);
    endfunction

    // a covers b
    function automatic bit covers(input t_entry a, input t_entry b);
        return (a.len <= b.len) && ((b.addr & mask_of(int'(a.len))) == a.addr);
    endfunction

    function automatic t_result status_item(input logic [STATUS_W-1:0] status, input int removed);
        t_result r;
        r = '0;
        r.kind    = KIND_ADD_STATUS;
        r.status  = status;
        r.removed = REMOVED_W'(removed);
        r.last    = 1'b1;
        return r;
    endfunction

    // append at the tail of the expected results
    function automatic void add_due(input t_result r);
        due_results.insert(due_results.size(), r);
    endfunction

    task automatic coalesce_item(input logic mode, input logic [ADDRESS_BITS-1:0] addr,
                                 input logic [LEN_W-1:0] len_in);
        t_entry  fresh;
        t_result r;
        int      removed;
        int      keep;
        if (mode == MODE_DRAIN) begin
            if (held_count == 0) begin
                r = '0;
                r.kind = KIND_EMPTY;
                r.last = 1'b1;
                add_due(r);
            end
            for (int i = 0; i < held_count; i++) begin
                r = '0;
                r.kind = KIND_DRAINED;
                r.addr = held[i].addr;
                r.len  = held[i].len;
                r.last = (i == held_count - 1);
                add_due(r);
            end
            held_count = 0;
            return;
        end
        fresh.len  = (len_in > ADDRESS_BITS) ? LEN_W'(ADDRESS_BITS) : len_in;
        fresh.addr = addr & mask_of(int'(fresh.len));
        // coverage by a stored entry is checked before anything is removed
        for (int i = 0; i < held_count; i++) begin
            if (covers(held[i], fresh)) begin
                add_due(status_item(STATUS_COVERED, 0));
                return;
            end
        end
        removed = 0;
        for (int i = 0; i < held_count; i++)
            if (covers(fresh, held[i]))
                removed++;
        if (held_count - removed >= MPC_TABLE_DEPTH) begin
            add_due(status_item(STATUS_FULL, 0));
            return;
        end
        keep = 0;
        for (int i = 0; i < held_count; i++) begin
            if (!covers(fresh, held[i])) begin
                held[keep] = held[i];
                keep++;
            end
        end
        held[keep] = fresh;
        held_count = keep + 1;
        add_due(status_item(STATUS_STORED, removed));
    endtask

    task automatic note_mismatch(input string what);
        o_error_count++;
        if (o_error_count <= 40)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("result %0d %s got %0h want %0h",
                                    o_result_count, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            held_count = 0;
            due_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                got.kind    = i_m_tuser;
                got.status  = i_m_tdata[1:0];
                got.removed = i_m_tdata[6:2];
                got.addr    = i_m_tdata[38:7];
                got.len     = i_m_tdata[44:39];
                got.last    = i_m_tlast;
                if (due_results.size() == 0) begin
                    note_mismatch($sformatf("result %0d arrived with nothing expected",
                                            o_result_count));
                end else begin
                    want = due_results[0];
                    due_results.delete(0);
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("add_status", 32'(got.status), 32'(want.status));
                    check_field("removed_count", 32'(got.removed), 32'(want.removed));
                    check_field("out_address", got.addr, want.addr);
                    check_field("out_length", 32'(got.len), 32'(want.len));
                    check_field("last", 32'(got.last), 32'(want.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                coalesce_item(i_s_tuser[0], i_s_tdata[31:0], i_s_tdata[37:32]);
        end
        o_pending_count = due_results.size();
    end

endmodule

FILE: tb/modified_prefix_coalescer_test.sv
`timescale 1ns / 1ps
module modified_prefix_coalescer_test;
    import mpc_pkg::*;
    import mpc_test_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 80;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    int error_count;
    int pending_count;
    int result_count;
    int add_items = 0;
    int drain_items = 0;
    int idle_cycles = 0;
    int rx_hold = 0;
    logic [9:0] rx_phase = '0;
    bit tx_steady = 1'b1;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    modified_prefix_coalescer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    prefix_table_checker table_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .i_m_tlast       (m_axis_tlast),
        .o_error_count   (error_count),
        .o_pending_count (pending_count),
        .o_result_count  (result_count)
    );

    // mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // random stalls of the receiver; no new stall starts while rx_phase[8] is set
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold <= 0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_phase[8] && $urandom_range(0, 5) == 0)
                rx_hold <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("modified_prefix_coalescer_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid stays high across back-to-back items; lowered for a gap or by wait_drained
    task automatic send_item(input logic mode, input logic [31:0] addr, input logic [5:0] len);
        int gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, len, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_DRAIN)
            drain_items++;
        else
            add_items++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // host_heavy: mostly long distinct prefixes, fills the table;
    // otherwise a few address families with short lengths so entries cover each other
    task automatic random_add(input bit host_heavy);
        logic [31:0] a;
        logic [5:0]  l;
        int          r;
        a = $urandom;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            l = 6'($urandom_range(0, 63));
        end else if (host_heavy ? (r < 85) : (r < 30)) begin
            a[31:24] = 8'hC8;
            l = 6'($urandom_range(28, 32));
        end else begin
            case ($urandom_range(0, 3))
                0: a[31:24] = 8'h0A;
                1: a[31:24] = 8'hAC;
                2: a[31:24] = 8'hC0;
                default: a[31:24] = 8'hFF;
            endcase
            a[23:20] = 4'($urandom_range(0, 3));
            l = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 40)) :
                                              6'($urandom_range(6, 24));
        end
        send_item(MODE_ADD, a, l);
    endtask

    task automatic random_run();
        int n;
        bit host_heavy;
        host_heavy = ($urandom_range(0, 2) == 0);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(16, 28) : $urandom_range(1, 12);
        tx_steady = ($urandom_range(0, 3) == 0);
        repeat (n) begin
            if ($urandom_range(0, 29) == 0)
                send_item(MODE_DRAIN, $urandom, 6'($urandom));
            else
                random_add(host_heavy);
        end
        send_item(MODE_DRAIN, $urandom, 6'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_steady = 1'b1;
        send_item(MODE_DRAIN, 32'h0, 6'd0);             // empty table
        send_item(MODE_ADD, 32'h0A12_3456, 6'd8);       // host bits set
        send_item(MODE_ADD, 32'h0A01_0000, 6'd16);      // already covered
        send_item(MODE_ADD, 32'h0B00_0001, 6'd63);      // length saturates
        send_item(MODE_ADD, 32'hC0A8_01FF, 6'd24);
        send_item(MODE_ADD, 32'hC0A8_0000, 6'd16);      // removes the /24
        send_item(MODE_ADD, 32'hFFFF_FFFF, 6'd0);       // covers everything
        send_item(MODE_DRAIN, 32'hFFFF_FFFF, 6'd63);
        for (int i = 0; i < MPC_TABLE_DEPTH; i++)
            send_item(MODE_ADD, 32'hFFFF_FFF0 + i, 6'd32);
        send_item(MODE_ADD, 32'h0000_0000, 6'd32);      // table full
        send_item(MODE_ADD, 32'hFFFF_FFFE, 6'd31);      // removes two entries, stores one
        send_item(MODE_DRAIN, 32'h0, 6'd0);
        wait_drained();

        while (add_items + drain_items < RANDOM_ITEMS + 30) begin
            random_run();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d add and %0d drain items, checked %0d result items",
                 add_items, drain_items, result_count);
        $display("runs mixed table fills, covered and covering prefixes, full drops and drains");
        if (error_count == 0)
            $display("modified_prefix_coalescer_test: clean");
        else
            $display("modified_prefix_coalescer_test: errors");
        $finish;
    end

endmodule
